/* sv/assert_macros.svh */
// Assertion helpers used by the checker file.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, masked while reset is active.
`define ALI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define ALI_ASSERT_IMP(lbl, ante, cons, msg) \
	`ALI_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ALI_ASSERT_NXT(lbl, ante, cons, msg) \
	`ALI_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* sv/ali_pkg.sv */
package ali_pkg;

	// Fixed field widths and default capacity
	localparam int POS_W = 9;
	localparam int VAL_W = 16;
	localparam int CNT_OUT_W = 9;
	localparam int CAPACITY_DEF = 256;

	// Operation codes
	typedef enum logic [2:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_BACK  = 3'd1,
		OP_INS_AT    = 3'd2,
		OP_REM_FRONT = 3'd3,
		OP_REM_BACK  = 3'd4,
		OP_REM_AT    = 3'd5,
		OP_READ      = 3'd6
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// Class of work an accepted transaction needs
	typedef enum logic [1:0] {
		K_NONE = 2'd0,
		K_INS  = 2'd1,
		K_REM  = 2'd2,
		K_RD   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]     data_out;
		logic [1:0]           status;
		logic [CNT_OUT_W-1:0] count;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic cap;       // capture request, start work
		logic rd_shift;  // read next neighbor, advance pointer
		logic wr_shift;  // write back the neighbor read last cycle
		logic latch;     // hold the removed value
		logic fin;       // update count, load result
		logic ld_now;    // load result straight from decode
		logic ld_rd;     // load result with read data
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_t   kind;
		status_t code;
		logic    more;   // entries left to move
	} dp_stat_t;

endpackage

/* sv/ali_stream_if.sv */
interface ali_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/array_list_insert_remove_top.sv */
// Rejected or unknown ops: result registered the cycle after acceptance. Read: via S_RD_GET.
// Insert at p shifts entries p..n-1 up from the back, then writes p; remove at p shifts later ones down.
// The list memory (one read, one write port) moves one entry a cycle, so shifts set latency.
// One transaction in flight; the next is taken once its result is registered and the slot is free or read.
// Reset clears the entry count and control; list memory contents are kept.
module array_list_insert_remove_top import ali_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ali_stream_if.sink   req,
	ali_stream_if.source rsp
);
	localparam int AW = $clog2(CAPACITY);

	ctl_cmd_t         cmd;
	dp_stat_t         stat;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [VAL_W-1:0] ram_wdata, ram_rdata;
	logic             ready, valid;
	rsp_t             rsp_data;
	req_t             req_data;

	assign req_data = req.data;
	assign req.ready = ready;
	assign rsp.valid = valid;
	assign rsp.data = rsp_data;

	ali_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.rsp_valid (valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ali_datapath #(.CAPACITY(CAPACITY)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.rsp_data  (rsp_data),
		.cmd       (cmd),
		.stat      (stat),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ali_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);
endmodule

/* sv/ali_ram.sv */
module ali_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* sv/ali_ctrl.sv */
module ali_ctrl import ali_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);
	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_REM_GET,
		S_RD_GET
	} state_t;

	state_t state_q, state_d;
	logic   wpend_q, wpend_d;
	logic   rsp_valid_q, rsp_valid_d;
	logic   acc;

	assign req_ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp_ready);
	assign acc = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		cmd = '0;
		state_d = state_q;
		wpend_d = wpend_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (stat.code != ST_OK || stat.kind == K_NONE) begin
						cmd.ld_now = 1'b1;
					end else begin
						cmd.cap = 1'b1;
						wpend_d = 1'b0;
						unique case (stat.kind)
							K_INS: state_d = S_SHIFT;
							K_REM: state_d = S_REM_GET;
							K_RD: state_d = S_RD_GET;
							default: state_d = S_IDLE;
						endcase
					end
				end
			end
			S_REM_GET: begin
				cmd.latch = 1'b1;
				cmd.rd_shift = stat.more;
				wpend_d = stat.more;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				// read of one entry overlaps the write of the one before
				cmd.wr_shift = wpend_q;
				cmd.rd_shift = stat.more;
				wpend_d = stat.more;
				if (!stat.more && !wpend_q) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_RD_GET: begin
				cmd.ld_rd = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Result slot: filled on completion, emptied on transaction out
	always_comb begin
		if (cmd.ld_now || cmd.fin || cmd.ld_rd) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end else begin
			rsp_valid_d = rsp_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wpend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			wpend_q <= wpend_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end
endmodule

/* sv/ali_datapath.sv */
module ali_datapath import ali_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  req_t                        req_data,
	output rsp_t                        rsp_data,
	input  ctl_cmd_t                    cmd,
	output dp_stat_t                    stat,
	output logic                        ram_we,
	output logic [$clog2(CAPACITY)-1:0] ram_waddr,
	output logic [VAL_W-1:0]            ram_wdata,
	output logic [$clog2(CAPACITY)-1:0] ram_raddr,
	input  logic [VAL_W-1:0]            ram_rdata
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0]    count_q, count_nxt, count_m1;
	logic             ins_q;
	logic [AW-1:0]    at_q, ptr_q, waddr_q, at_c, shift_addr;
	logic [VAL_W-1:0] val_q, data_q;
	rsp_t             rsp_q;
	logic [PW-1:0]    pos_x, cnt_x;
	logic             full, empty;
	kind_t            kind_c;
	status_t          code_c;
	logic [CW+CNT_OUT_W-1:0] cnt_cur_x, cnt_nxt_x;

	assign pos_x = PW'(req_data.position);
	assign cnt_x = PW'(count_q);
	assign full = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign count_m1 = count_q - CW'(1);

	// Decode: checks and effective position
	always_comb begin
		kind_c = K_NONE;
		code_c = ST_OK;
		at_c = '0;
		unique case (req_data.op)
			OP_INS_FRONT: begin
				kind_c = K_INS;
				if (full) code_c = ST_FULL;
			end
			OP_INS_BACK: begin
				kind_c = K_INS;
				at_c = count_q[AW-1:0];
				if (full) code_c = ST_FULL;
			end
			OP_INS_AT: begin
				kind_c = K_INS;
				at_c = pos_x[AW-1:0];
				if (full) code_c = ST_FULL;
				else if (pos_x > cnt_x) code_c = ST_BADPOS;
			end
			OP_REM_FRONT: begin
				kind_c = K_REM;
				if (empty) code_c = ST_EMPTY;
			end
			OP_REM_BACK: begin
				kind_c = K_REM;
				at_c = count_m1[AW-1:0];
				if (empty) code_c = ST_EMPTY;
			end
			OP_REM_AT: begin
				kind_c = K_REM;
				at_c = pos_x[AW-1:0];
				if (empty) code_c = ST_EMPTY;
				else if (pos_x >= cnt_x) code_c = ST_BADPOS;
			end
			OP_READ: begin
				kind_c = K_RD;
				at_c = pos_x[AW-1:0];
				if (empty) code_c = ST_EMPTY;
				else if (pos_x >= cnt_x) code_c = ST_BADPOS;
			end
			default: kind_c = K_NONE;
		endcase
	end

	// Shift walk: insert goes down toward the gap, remove goes up
	assign shift_addr = ins_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
	assign stat.kind = kind_c;
	assign stat.code = code_c;
	assign stat.more = ins_q ? (ptr_q > at_q) : ((CW'(ptr_q) + CW'(1)) < count_q);

	// Memory port
	assign ram_raddr = cmd.rd_shift ? shift_addr : at_c;
	assign ram_we = cmd.wr_shift || (cmd.fin && ins_q);
	assign ram_waddr = cmd.wr_shift ? waddr_q : at_q;
	assign ram_wdata = cmd.wr_shift ? ram_rdata : val_q;

	assign count_nxt = ins_q ? (count_q + CW'(1)) : count_m1;
	assign cnt_cur_x = {{CNT_OUT_W{1'b0}}, count_q};
	assign cnt_nxt_x = {{CNT_OUT_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.fin) begin
			count_q <= count_nxt;
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			ins_q <= (kind_c == K_INS);
			at_q <= at_c;
			ptr_q <= (kind_c == K_INS) ? count_q[AW-1:0] : at_c;
			val_q <= req_data.value;
		end else if (cmd.rd_shift) begin
			waddr_q <= ptr_q;
			ptr_q <= shift_addr;
		end
		if (cmd.latch) begin
			data_q <= ram_rdata;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.ld_now) begin
			rsp_q.data_out <= '0;
			rsp_q.status <= code_c;
			rsp_q.count <= cnt_cur_x[CNT_OUT_W-1:0];
		end else if (cmd.ld_rd) begin
			rsp_q.data_out <= ram_rdata;
			rsp_q.status <= ST_OK;
			rsp_q.count <= cnt_cur_x[CNT_OUT_W-1:0];
		end else if (cmd.fin) begin
			rsp_q.data_out <= ins_q ? '0 : data_q;
			rsp_q.status <= ST_OK;
			rsp_q.count <= cnt_nxt_x[CNT_OUT_W-1:0];
		end
	end

	assign rsp_data = rsp_q;
endmodule

/* sv/ali_checker.sv */
`include "assert_macros.svh"

module ali_checker import ali_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);
	logic                 req_acc, rsp_acc;
	logic [1:0]           pend_q;
	logic                 seen_q;
	logic [CNT_OUT_W-1:0] last_q;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	// Transactions in minus results out, last reported count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			seen_q <= 1'b0;
			last_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, req_acc} - {1'b0, rsp_acc};
			if (rsp_acc) begin
				seen_q <= 1'b1;
				last_q <= rsp_data.count;
			end
		end
	end

	// A result only for a transaction taken earlier
	`ALI_ASSERT_IMP(a_no_extra_rsp, rsp_valid, pend_q != 2'd0, "result without request")

	// Each operation moves the count by at most one
	`ALI_ASSERT_IMP(a_count_step, rsp_acc && seen_q,
		(rsp_data.count == last_q) || (rsp_data.count == last_q + CNT_OUT_W'(1)) ||
		(rsp_data.count == last_q - CNT_OUT_W'(1)), "count jumped")

	// Empty status goes with a zero count
	`ALI_ASSERT_IMP(a_empty_cnt, rsp_valid && (rsp_data.status == ST_EMPTY),
		rsp_data.count == '0, "empty with entries")

	// Full status goes with a count at capacity
	`ALI_ASSERT_IMP(a_full_cnt, rsp_valid && (rsp_data.status == ST_FULL),
		rsp_data.count == CNT_OUT_W'(CAPACITY), "full below capacity")

	// A stalled result holds
	`ALI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_data), "stalled result changed")
endmodule

bind array_list_insert_remove_top ali_checker #(.CAPACITY(CAPACITY)) u_ali_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
